// ===== design/rrrl_pkg.sv =====
package rrrl_pkg;

	// List geometry
	localparam int MAX_TASKS = 64;
	localparam int IDX_W     = $clog2(MAX_TASKS);
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);
	localparam int ID_W      = 6;
	localparam int STEP_W    = 5;

	// Command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_NEXT   = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	typedef logic [STEP_W-1:0] step_t;

	// Datapath actions, one per control word
	typedef enum logic [3:0] {
		A_NONE,
		A_ACCEPT,
		A_RES_OK,
		A_RES_FULL,
		A_RES_EMPTY,
		A_RES_MISS,
		A_APPEND,
		A_SCAN_INIT,
		A_SCAN_STEP,
		A_READ_NEXT,
		A_SHIFT_WR,
		A_REMOVE_DONE,
		A_CUR_ADV,
		A_CUR_ZERO,
		A_PICK,
		A_EMIT
	} act_t;

	// Jump conditions
	typedef enum logic [3:0] {
		C_ALWAYS,
		C_NO_IN,
		C_CMD_INS,
		C_CMD_REM,
		C_CMD_NXT,
		C_FULL,
		C_ZERO,
		C_ONE,
		C_MATCH,
		C_PTR_LAST,
		C_NOT_LAST,
		C_OUT_FREE
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		step_t target;
	} ucode_t;

	// Datapath flags seen by the sequencer
	typedef struct packed {
		logic no_in;
		logic cmd_ins;
		logic cmd_rem;
		logic cmd_nxt;
		logic full;
		logic zero;
		logic one;
		logic match;
		logic ptr_last;
		logic out_free;
	} flags_t;

	// Program step addresses
	localparam step_t S_IDLE     = 5'd0;
	localparam step_t S_DSP_INS  = 5'd1;
	localparam step_t S_DSP_REM  = 5'd2;
	localparam step_t S_DSP_NXT  = 5'd3;
	localparam step_t S_RES_OK   = 5'd4;
	localparam step_t S_INS      = 5'd5;
	localparam step_t S_INS_WR   = 5'd6;
	localparam step_t S_FULL     = 5'd7;
	localparam step_t S_REM      = 5'd8;
	localparam step_t S_REM_ONE  = 5'd9;
	localparam step_t S_SCAN0    = 5'd10;
	localparam step_t S_SCAN_CMP = 5'd11;
	localparam step_t S_SCAN_INC = 5'd12;
	localparam step_t S_MISS     = 5'd13;
	localparam step_t S_SHF_CHK  = 5'd14;
	localparam step_t S_SHF_WR   = 5'd15;
	localparam step_t S_REM_DONE = 5'd16;
	localparam step_t S_EMPTY    = 5'd17;
	localparam step_t S_NXT      = 5'd18;
	localparam step_t S_NXT_ONE  = 5'd19;
	localparam step_t S_NXT_ADV  = 5'd20;
	localparam step_t S_NXT_ZERO = 5'd21;
	localparam step_t S_NXT_PICK = 5'd22;
	localparam step_t S_EMIT     = 5'd23;
	localparam step_t S_EMIT_W   = 5'd24;

	// Control store: a taken condition jumps to target, else fall through
	function automatic ucode_t ucode(input step_t step);
		ucode_t w;
		unique case (step)
			S_IDLE:     w = '{A_ACCEPT,      C_NO_IN,    S_IDLE};
			S_DSP_INS:  w = '{A_NONE,        C_CMD_INS,  S_INS};
			S_DSP_REM:  w = '{A_NONE,        C_CMD_REM,  S_REM};
			S_DSP_NXT:  w = '{A_NONE,        C_CMD_NXT,  S_NXT};
			S_RES_OK:   w = '{A_RES_OK,      C_ALWAYS,   S_EMIT};
			S_INS:      w = '{A_NONE,        C_FULL,     S_FULL};
			S_INS_WR:   w = '{A_APPEND,      C_ALWAYS,   S_EMIT};
			S_FULL:     w = '{A_RES_FULL,    C_ALWAYS,   S_EMIT};
			S_REM:      w = '{A_NONE,        C_ZERO,     S_EMPTY};
			S_REM_ONE:  w = '{A_NONE,        C_ONE,      S_RES_OK};
			S_SCAN0:    w = '{A_SCAN_INIT,   C_ALWAYS,   S_SCAN_CMP};
			S_SCAN_CMP: w = '{A_NONE,        C_MATCH,    S_SHF_CHK};
			S_SCAN_INC: w = '{A_SCAN_STEP,   C_NOT_LAST, S_SCAN_CMP};
			S_MISS:     w = '{A_RES_MISS,    C_ALWAYS,   S_EMIT};
			S_SHF_CHK:  w = '{A_READ_NEXT,   C_PTR_LAST, S_REM_DONE};
			S_SHF_WR:   w = '{A_SHIFT_WR,    C_ALWAYS,   S_SHF_CHK};
			S_REM_DONE: w = '{A_REMOVE_DONE, C_ALWAYS,   S_EMIT};
			S_EMPTY:    w = '{A_RES_EMPTY,   C_ALWAYS,   S_EMIT};
			S_NXT:      w = '{A_NONE,        C_ZERO,     S_EMPTY};
			S_NXT_ONE:  w = '{A_NONE,        C_ONE,      S_NXT_ZERO};
			S_NXT_ADV:  w = '{A_CUR_ADV,     C_ALWAYS,   S_NXT_PICK};
			S_NXT_ZERO: w = '{A_CUR_ZERO,    C_ALWAYS,   S_NXT_PICK};
			S_NXT_PICK: w = '{A_PICK,        C_ALWAYS,   S_EMIT};
			S_EMIT:     w = '{A_EMIT,        C_OUT_FREE, S_IDLE};
			S_EMIT_W:   w = '{A_NONE,        C_ALWAYS,   S_EMIT};
			default:    w = '{A_NONE,        C_ALWAYS,   S_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== design/rrrl_seq.sv =====
module rrrl_seq import rrrl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  flags_t flags,
	output act_t   act
);

	step_t  pc_q;
	ucode_t word;
	logic   taken;

	// Fetch the control word
	assign word = ucode(pc_q);
	assign act  = word.act;

	// Select the jump condition
	always_comb begin
		unique case (word.cond)
			C_ALWAYS:   taken = 1'b1;
			C_NO_IN:    taken = flags.no_in;
			C_CMD_INS:  taken = flags.cmd_ins;
			C_CMD_REM:  taken = flags.cmd_rem;
			C_CMD_NXT:  taken = flags.cmd_nxt;
			C_FULL:     taken = flags.full;
			C_ZERO:     taken = flags.zero;
			C_ONE:      taken = flags.one;
			C_MATCH:    taken = flags.match;
			C_PTR_LAST: taken = flags.ptr_last;
			C_NOT_LAST: taken = !flags.ptr_last;
			C_OUT_FREE: taken = flags.out_free;
			default:    taken = 1'b0;
		endcase
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else if (taken) begin
			pc_q <= word.target;
		end else begin
			pc_q <= pc_q + step_t'(1);
		end
	end

endmodule

// ===== design/rrrl_dp.sv =====
module rrrl_dp import rrrl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  act_t             act,
	output flags_t           flags,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       cmd,
	input  logic [ID_W-1:0]  task_id,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [ID_W-1:0]  picked_id,
	output logic [1:0]       status,
	output logic [CNT_W-1:0] entries
);

	logic [ID_W-1:0]  mem [MAX_TASKS];
	logic [ID_W-1:0]  rd_q;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [ID_W-1:0]  wr_data;

	logic [1:0]       cmd_q;
	logic [ID_W-1:0]  id_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] cursor_q;
	logic [IDX_W-1:0] ptr_q;
	logic [ID_W-1:0]  res_pick_q;
	logic [1:0]       res_status_q;
	logic             out_valid_q;
	logic [ID_W-1:0]  out_pick_q;
	logic [1:0]       out_status_q;
	logic [CNT_W-1:0] out_count_q;

	logic [CNT_W-1:0] ptr_inc;
	logic [CNT_W-1:0] cur_inc;
	logic [IDX_W-1:0] cur_next;
	logic             out_free;

	assign ptr_inc  = {1'b0, ptr_q} + CNT_W'(1);
	assign cur_inc  = {1'b0, cursor_q} + CNT_W'(1);
	assign cur_next = (cur_inc >= count_q) ? IDX_W'(1) : cur_inc[IDX_W-1:0];
	assign out_free = !out_valid_q || out_ready;

	// Status flags for the sequencer
	always_comb begin
		flags.no_in    = !in_valid;
		flags.cmd_ins  = (cmd_q == CMD_INSERT);
		flags.cmd_rem  = (cmd_q == CMD_REMOVE);
		flags.cmd_nxt  = (cmd_q == CMD_NEXT);
		flags.full     = (count_q == CNT_W'(MAX_TASKS));
		flags.zero     = (count_q == '0);
		flags.one      = (count_q == CNT_W'(1));
		flags.match    = (rd_q == id_q);
		flags.ptr_last = (ptr_inc >= count_q);
		flags.out_free = out_free;
	end

	// Memory port control
	always_comb begin
		rd_addr = ptr_q;
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = rd_q;
		case (act) inside
			A_APPEND: begin
				wr_en   = 1'b1;
				wr_addr = count_q[IDX_W-1:0];
				wr_data = id_q;
			end
			A_SCAN_INIT: rd_addr = '0;
			A_SCAN_STEP, A_READ_NEXT: rd_addr = ptr_inc[IDX_W-1:0];
			A_SHIFT_WR: wr_en = 1'b1;
			A_CUR_ADV: rd_addr = cur_next;
			A_CUR_ZERO: rd_addr = '0;
			default: ;
		endcase
	end

	// Ordered list storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// Capture the accepted transaction
	assign in_ready = (act == A_ACCEPT);

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_q <= cmd;
			id_q  <= task_id;
		end
	end

	// List count, cursor and scan pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
			ptr_q    <= '0;
		end else begin
			case (act)
				A_APPEND:      count_q  <= count_q + CNT_W'(1);
				A_REMOVE_DONE: count_q  <= count_q - CNT_W'(1);
				A_SCAN_INIT:   ptr_q    <= '0;
				A_SCAN_STEP:   ptr_q    <= ptr_inc[IDX_W-1:0];
				A_SHIFT_WR:    ptr_q    <= ptr_inc[IDX_W-1:0];
				A_CUR_ADV:     cursor_q <= cur_next;
				A_CUR_ZERO:    cursor_q <= '0;
				default: ;
			endcase
		end
	end

	// Result of the current command
	always_ff @(posedge clk) begin
		case (act) inside
			A_RES_OK, A_APPEND, A_REMOVE_DONE: begin
				res_pick_q   <= '0;
				res_status_q <= ST_OK;
			end
			A_RES_FULL: begin
				res_pick_q   <= '0;
				res_status_q <= ST_FULL;
			end
			A_RES_EMPTY: begin
				res_pick_q   <= '0;
				res_status_q <= ST_EMPTY;
			end
			A_RES_MISS: begin
				res_pick_q   <= '0;
				res_status_q <= ST_NOT_FOUND;
			end
			A_PICK: begin
				res_pick_q   <= rd_q;
				res_status_q <= ST_OK;
			end
			default: ;
		endcase
	end

	// Output register: load on emit once the slot is free, drop on take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (act == A_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (act == A_EMIT && out_free) begin
			out_pick_q   <= res_pick_q;
			out_status_q <= res_status_q;
			out_count_q  <= count_q;
		end
	end

	assign out_valid = out_valid_q;
	assign picked_id = out_pick_q;
	assign status    = out_status_q;
	assign entries   = out_count_q;

endmodule

// ===== design/round_robin_ready_list_top.sv =====
// Round-robin ready list: an ordered, compacted list of up to 64 task ids with
// entry 0 kept for the idle task. Commands are insert (append), remove (search,
// then shift later entries down; a lone entry is left in place) and pick next
// (round-robin over entries 1 and up, or entry 0 when it stands alone); each
// transaction returns one result with the picked id, a status code and the
// entry count. A small microcoded sequencer steps a datapath around a list
// memory with one write port and one registered read port, so one transaction
// is handled at a time. Remove makes a compare and a step for each entry up to
// the match, then a read and a write for each entry after it. The sequencer
// passes through the idle step before the next transaction is taken, and a
// result still held in the output register stalls the sequencer until taken.
module round_robin_ready_list_top import rrrl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       cmd,
	input  logic [ID_W-1:0]  task_id,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [ID_W-1:0]  picked_id,
	output logic [1:0]       status,
	output logic [CNT_W-1:0] entries
);

	act_t   act;
	flags_t flags;

	// Control sequencer
	rrrl_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.act    (act)
	);

	// List datapath
	rrrl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.act       (act),
		.flags     (flags),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.task_id   (task_id),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.picked_id (picked_id),
		.status    (status),
		.entries   (entries)
	);

endmodule

// ===== tb/round_robin_ready_list_top_tb.sv =====
module round_robin_ready_list_top_tb;
	import rrrl_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 150;

	typedef struct packed {
		logic [ID_W-1:0]  picked;
		logic [1:0]       status;
		logic [CNT_W-1:0] count;
	} list_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [1:0]       cmd = CMD_INSERT;
	logic [ID_W-1:0]  task_id = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [ID_W-1:0]  picked_id;
	logic [1:0]       status;
	logic [CNT_W-1:0] entries;

	// Predicted list state
	logic [ID_W-1:0] list_ids [MAX_TASKS];
	int              list_len = 0;
	int              rr_pos = 0;
	int              peak_len = 0;

	list_result_t pending_results [$];
	int           errors = 0;
	int           cycles = 0;
	int           no_idle = 0;
	int           hold_req = 0;
	int           cmd_seen [4] = '{0, 0, 0, 0};
	int           status_seen [4] = '{0, 0, 0, 0};

	round_robin_ready_list_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.task_id   (task_id),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.picked_id (picked_id),
		.status    (status),
		.entries   (entries)
	);

	always #5 clk = ~clk;

	// Advance the predicted list by one command and return the expected result
	function automatic list_result_t ready_list_step(input logic [1:0] op,
			input logic [ID_W-1:0] id);
		list_result_t r;
		int pos;
		int nxt;
		r.picked = '0;
		r.status = ST_OK;
		case (op)
			CMD_INSERT: begin
				if (list_len >= MAX_TASKS) begin
					r.status = ST_FULL;
				end else begin
					list_ids[list_len] = id;
					list_len++;
				end
			end
			CMD_REMOVE: begin
				if (list_len == 0) begin
					r.status = ST_EMPTY;
				end else if (list_len > 1) begin
					pos = list_len;
					for (int k = 0; k < list_len; k++)
						if (pos == list_len && list_ids[k] == id)
							pos = k;
					if (pos == list_len) begin
						r.status = ST_NOT_FOUND;
					end else begin
						for (int k = pos; k + 1 < list_len; k++)
							list_ids[k] = list_ids[k + 1];
						list_len--;
					end
				end
			end
			CMD_NEXT: begin
				if (list_len == 0) begin
					r.status = ST_EMPTY;
				end else if (list_len == 1) begin
					rr_pos = 0;
					r.picked = list_ids[0];
				end else begin
					nxt = rr_pos + 1;
					if (nxt >= list_len)
						nxt = 1;
					rr_pos = nxt;
					r.picked = list_ids[nxt];
				end
			end
			default: ;
		endcase
		r.count = list_len[CNT_W-1:0];
		if (list_len > peak_len)
			peak_len = list_len;
		cmd_seen[op]++;
		status_seen[r.status]++;
		return r;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int gap_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 4);
		return $urandom_range(15, 60);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	// Offer one transaction, hold it until accepted, then predict its result
	task automatic send_item(input logic [1:0] op, input logic [ID_W-1:0] id);
		in_valid <= 1'b1;
		cmd <= op;
		task_id <= id;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(ready_list_step(op, id));
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every predicted result has arrived
	task automatic wait_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	function automatic logic [ID_W-1:0] present_id();
		if (list_len == 0)
			return ID_W'($urandom_range(0, 63));
		return list_ids[$urandom_range(0, list_len - 1)];
	endfunction

	task automatic test_directed();
		send_item(CMD_NEXT, 6'd0);
		send_item(CMD_REMOVE, 6'd5);
		send_item(CMD_UNUSED, 6'd0);
		send_item(CMD_INSERT, 6'd0);
		send_item(CMD_NEXT, 6'd0);
		send_item(CMD_REMOVE, 6'd0);
		send_item(CMD_INSERT, 6'd63);
		send_item(CMD_INSERT, 6'd21);
		send_item(CMD_INSERT, 6'd42);
		send_item(CMD_NEXT, 6'd63);
		send_item(CMD_NEXT, 6'd0);
		send_item(CMD_NEXT, 6'd0);
		// cursor now past the end after the removal
		send_item(CMD_REMOVE, 6'd21);
		send_item(CMD_NEXT, 6'd0);
		send_item(CMD_REMOVE, 6'd7);
		// the idle entry itself may be removed
		send_item(CMD_REMOVE, 6'd0);
		send_item(CMD_NEXT, 6'd0);
		send_item(CMD_UNUSED, 6'd63);
		send_item(CMD_REMOVE, 6'd63);
		send_item(CMD_REMOVE, 6'd42);
		wait_drain();
	endtask

	// Fill to capacity under a long output hold-off, walk the cursor, then remove down to a single entry
	task automatic test_fill_drain();
		hold_req = 400;
		while (list_len < MAX_TASKS)
			send_item(CMD_INSERT, ID_W'($urandom_range(0, 63)));
		send_item(CMD_INSERT, ID_W'($urandom_range(0, 63)));
		send_item(CMD_INSERT, 6'd63);
		repeat (70)
			send_item(CMD_NEXT, ID_W'($urandom_range(0, 63)));
		send_item(CMD_REMOVE, list_ids[list_len - 1]);
		send_item(CMD_REMOVE, list_ids[0]);
		while (list_len > 1)
			send_item(CMD_REMOVE, present_id());
		send_item(CMD_REMOVE, present_id());
		send_item(CMD_NEXT, 6'd0);
		wait_drain();
	endtask

	// Weighted mix that drifts the list length between targets
	task automatic test_random_mix(input int n_items);
		int target;
		int ins_pct;
		int r;
		target = 8;
		for (int i = 0; i < n_items; i++) begin
			if (i % 80 == 0)
				target = $urandom_range(0, 4) == 0 ? MAX_TASKS : $urandom_range(2, 40);
			ins_pct = (list_len < target) ? 55 : 20;
			r = $urandom_range(0, 99);
			if (r < ins_pct)
				send_item(CMD_INSERT, ID_W'($urandom_range(0, 63)));
			else if (r < ins_pct + 25)
				send_item(CMD_REMOVE, present_id());
			else if (r < ins_pct + 30)
				send_item(CMD_REMOVE, ID_W'($urandom_range(0, 63)));
			else if (r < 97)
				send_item(CMD_NEXT, ID_W'($urandom_range(0, 63)));
			else
				send_item(CMD_UNUSED, ID_W'($urandom_range(0, 63)));
			if ($urandom_range(0, 199) == 0)
				wait_drain();
		end
		wait_drain();
	endtask

	task automatic test_back_to_back(input int n_items);
		no_idle = 1;
		test_random_mix(n_items);
		no_idle = 0;
	endtask

	// Drive out_ready: random stalls, plus a long hold-off on request
	always begin : drive_out_ready
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0 && !no_idle) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				stall_left = 0;
				if (!no_idle && $urandom_range(0, 3) == 0)
					stall_left = gap_len();
			end
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, entries", entries, 0);
			end else begin
				want = pending_results.pop_front();
				if (picked_id !== want.picked)
					report_mismatch("picked_id", picked_id, want.picked);
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (entries !== want.count)
					report_mismatch("entries", entries, want.count);
			end
		end
	end

	// Hold the run to a cycle budget
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("round_robin_ready_list_top: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_drain();
		test_random_mix(520);
		test_back_to_back(110);
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never returned", 0, pending_results.size());
		$display("ran %0d inserts, %0d removes, %0d picks, %0d unused commands",
			cmd_seen[CMD_INSERT], cmd_seen[CMD_REMOVE], cmd_seen[CMD_NEXT],
			cmd_seen[CMD_UNUSED]);
		$display("saw %0d full, %0d not found, %0d empty; longest list %0d entries",
			status_seen[ST_FULL], status_seen[ST_NOT_FOUND], status_seen[ST_EMPTY],
			peak_len);
		if (errors == 0)
			$display("round_robin_ready_list_top: match");
		else
			$display("round_robin_ready_list_top: mismatch");
		$finish;
	end

endmodule
